/* rtl/core/mmfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfc_pkg: shared types and constants
// Mode codes, operation selects, the arithmetic unit control struct and the CRC lookup ROM.
// ----------------------------------------------------------------------------
package mmfc_pkg;

   localparam logic [1:0] MODE_SUM    = 2'd0;
   localparam logic [1:0] MODE_ROTATE = 2'd1;
   localparam logic [1:0] MODE_CRC    = 2'd2;
   localparam logic [1:0] MODE_ALT    = 2'd3;

   // Operation selects for the shared arithmetic unit.
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_ROT  = 3'd1;
   localparam logic [2:0] OP_CRC  = 3'd2;
   localparam logic [2:0] OP_FOLD = 3'd3;
   localparam logic [2:0] OP_NOT  = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] octet;
   } alu_ctrl_type;

   function automatic logic [31:0] crc_rom(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/core/mmfc_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfc_alu: shared checksum arithmetic unit
// One add, rotate-add, table CRC step, half fold or complement per cycle.
// ----------------------------------------------------------------------------
module mmfc_alu (
   input  mmfc_pkg::alu_ctrl_type ctrl,
   input  logic [31:0]            acc,
   output logic [31:0]            result
);
   import mmfc_pkg::*;

   logic [15:0] rot;

   always_comb begin
      rot = {acc[0], acc[15:1]};
      case (ctrl.op)
         OP_ADD:  result = acc + {24'd0, ctrl.octet};
         OP_ROT:  result = {16'd0, rot + {8'd0, ctrl.octet}};
         OP_CRC:  result = {acc[23:0], 8'd0} ^ crc_rom(acc[31:24] ^ ctrl.octet);
         OP_FOLD: result = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
         OP_NOT:  result = ~acc;
         default: result = acc;
      endcase
   end
endmodule

/* rtl/core/multi_mode_file_checksum_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_file_checksum_unit: stream checksum (sum / cksum family)
// Byte sum, rotate-add sum or table CRC with appended length over a stream.
// ----------------------------------------------------------------------------
// A byte word is taken while the unit is idle. A word that closes the stream
// then runs a short finish sequence on the single shared arithmetic unit: two
// fold steps (FOLD1, FOLD2) in modes 0 and 3; in mode 2 one CRC step for each
// length byte up to the highest nonzero one (none for an empty stream, at most
// four) plus one complement step; mode 1 needs none. The DONE state then loads
// the output register, and the input stays stalled until that result has been
// taken. A word that does not close the stream leaves the unit idle and ready
// for the next word; after a closing word the next word waits for the finish
// sequence, the DONE state and the taking of the result. The block count for
// modes 0, 1 and 3 is kept as the stream runs, so no divide is needed.
module multi_mode_file_checksum_unit #(
   parameter int BLOCK_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_check_value,
   output logic [31:0] rsp_size_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_sum_mode
);
   import mmfc_pkg::*;

   localparam int BLK_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [BLK_W-1:0] OFF_LAST = BLK_W'(BLOCK_BYTES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FOLD1 = 3'd1;
   localparam logic [2:0] ST_FOLD2 = 3'd2;
   localparam logic [2:0] ST_LEN   = 3'd3;
   localparam logic [2:0] ST_NOT   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] shift_ff, shift_in;
   logic [BLK_W-1:0] off_ff, off_in;
   logic [31:0] blk_ff, blk_in;
   logic        rv_ff;
   logic [31:0] chk_ff, size_ff;
   logic        accept, take_out;
   alu_ctrl_type ctrl;
   logic [31:0] alu_res;

   mmfc_alu u_alu (.ctrl(ctrl), .acc(acc_ff), .result(alu_res));

   assign take_out  = rv_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      ctrl.octet = req_data_byte;
      unique case (mode_ff)
         MODE_ROTATE: ctrl.op = OP_ROT;
         MODE_CRC:    ctrl.op = OP_CRC;
         default:     ctrl.op = OP_ADD;
      endcase
      if (state_ff == ST_FOLD1 || state_ff == ST_FOLD2) ctrl.op = OP_FOLD;
      if (state_ff == ST_LEN) begin
         ctrl.op = OP_CRC;
         ctrl.octet = shift_ff[7:0];
      end
      if (state_ff == ST_NOT) ctrl.op = OP_NOT;
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      total_in = total_ff;
      shift_in = shift_ff;
      off_in   = off_ff;
      blk_in   = blk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_has_byte) begin
                  acc_in   = alu_res;
                  total_in = total_ff + 32'd1;
                  // A wrapping byte count starts the block count over as well.
                  if (total_ff == 32'hffff_ffff) begin
                     off_in = '0;
                     blk_in = 32'd0;
                  end else begin
                     if (off_ff == '0) blk_in = blk_ff + 32'd1;
                     off_in = (off_ff == OFF_LAST) ? '0 : off_ff + BLK_W'(1);
                  end
               end
               if (req_end_of_stream) begin
                  shift_in = total_in;
                  unique case (mode_ff)
                     MODE_ROTATE: state_in = ST_DONE;
                     MODE_CRC: state_in = (total_in != 32'd0) ? ST_LEN : ST_NOT;
                     default:  state_in = ST_FOLD1;
                  endcase
               end
            end
         end
         ST_FOLD1: begin
            acc_in   = alu_res;
            state_in = ST_FOLD2;
         end
         ST_FOLD2: begin
            acc_in   = alu_res;
            state_in = ST_DONE;
         end
         ST_LEN: begin
            acc_in   = alu_res;
            shift_in = shift_ff >> 8;
            if ((shift_ff >> 8) == 32'd0) state_in = ST_NOT;
         end
         ST_NOT: begin
            acc_in   = alu_res;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            acc_in   = 32'd0;
            total_in = 32'd0;
            shift_in = 32'd0;
            off_in   = '0;
            blk_in   = 32'd0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_SUM;
         acc_ff   <= 32'd0;
         total_ff <= 32'd0;
         shift_ff <= 32'd0;
         off_ff   <= '0;
         blk_ff   <= 32'd0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         total_ff <= total_in;
         shift_ff <= shift_in;
         off_ff   <= off_in;
         blk_ff   <= blk_in;
         if (csr_valid && csr_ready) mode_ff <= csr_sum_mode;
         if (state_ff == ST_DONE) rv_ff <= 1'b1;
         else if (take_out) rv_ff <= 1'b0;
      end
   end

   // Mode 1 reports only the low half, even if an earlier mode of the same
   // stream left the upper half set.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         chk_ff  <= (mode_ff == MODE_ROTATE) ? {16'd0, acc_ff[15:0]} : acc_ff;
         size_ff <= (mode_ff == MODE_CRC) ? total_ff : blk_ff;
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_check_value = chk_ff;
   assign rsp_size_value  = size_ff;
endmodule

/* rtl/core/mmfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmfc_checker: port-level checks
// Watches the handshakes of the checksum unit over time.
// ----------------------------------------------------------------------------
module mmfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_end_of_stream,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_check_value
);
   // A closing word keeps the input stalled on the next cycle.
   a_eos_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_stream |=> req_stall)
      else $error("input not stalled after closing word");

   // No input is taken while a result waits.
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   // A pending stalled result stays.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_check_value))
      else $error("result dropped or changed while stalled");
endmodule

bind multi_mode_file_checksum_unit mmfc_checker u_mmfc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_end_of_stream(req_end_of_stream), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_check_value(rsp_check_value)
);
